### design/sawm_pkg.sv
`timescale 1ns / 1ps

package sawm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ALPHABET   = 26;

    localparam int LETTER_W = 5;
    localparam int ACTION_W = 2;
    localparam int POS_W    = 32;
    localparam int RING_AW  = $clog2(MAX_WINDOW);
    localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W    = LEN_W + 1;
    localparam int TALLY_W  = $clog2(ALPHABET + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int IN_DATA_W  = 8;
    localparam int RESULT_W   = 1 + POS_W + 1;
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEXT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TEXT  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [LETTER_W-1:0] letter;
        logic                remove;
        logic                match_ok;
        logic [POS_W-1:0]    start;
        logic                error;
    } item_t;

    typedef struct packed {
        logic             error;
        logic [POS_W-1:0] start_index;
        logic             match;
    } result_t;

endpackage

### design/sawm_ctrl.sv
`timescale 1ns / 1ps

module sawm_ctrl
    import sawm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [LETTER_W-1:0] letter,
    output logic                item_valid,
    output item_t               item,
    output logic [LETTER_W-1:0] old_letter
);

    localparam logic [LETTER_W:0] ALPHA_LIM = (LETTER_W + 1)'(ALPHABET);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_WINDOW);
    localparam logic [LEN_W:0]    RING_SPAN = (LEN_W + 1)'(MAX_WINDOW);
    localparam logic [RING_AW-1:0] PTR_LAST = RING_AW'(MAX_WINDOW - 1);

    logic [LETTER_W-1:0] ring_mem [0:MAX_WINDOW-1];

    logic [LEN_W-1:0]    len_reg, len_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [RING_AW-1:0]  ptr_reg, ptr_next;
    logic                started_reg, started_next;
    logic                item_valid_reg;
    item_t               item_reg, item_next;
    logic [LETTER_W-1:0] old_letter_reg;

    logic                accept;
    logic                letter_ok;
    logic                load_ok;
    logic [LEN_W-1:0]    len_m1;
    logic [LEN_W:0]      old_wide;
    logic [RING_AW-1:0]  old_addr;
    logic                ring_we;

    assign accept    = in_valid & in_ready;
    assign letter_ok = {1'b0, letter} < ALPHA_LIM;
    assign load_ok   = !started_reg && (len_reg < LEN_MAX) && letter_ok;
    assign len_m1    = len_reg - LEN_W'(1);

    always_comb
    begin
        if ({1'b0, LEN_W'(ptr_reg)} >= {1'b0, len_reg})
        begin
            old_wide = {1'b0, LEN_W'(ptr_reg)} - {1'b0, len_reg};
        end
        else
        begin
            old_wide = {1'b0, LEN_W'(ptr_reg)} + RING_SPAN - {1'b0, len_reg};
        end
    end

    assign old_addr = old_wide[RING_AW-1:0];

    always_comb
    begin
        len_next     = len_reg;
        pos_next     = pos_reg;
        ptr_next     = ptr_reg;
        started_next = started_reg;
        ring_we      = 1'b0;
        item_next    = '{op: OP_NONE, letter: letter, remove: 1'b0, match_ok: 1'b0,
                         start: '0, error: 1'b0};
        unique case (action)
            ACT_LOAD:
            begin
                if (load_ok)
                begin
                    len_next     = len_reg + LEN_W'(1);
                    item_next.op = OP_LOAD;
                end
                else
                begin
                    item_next.error = 1'b1;
                end
            end
            ACT_TEXT:
            begin
                if (letter_ok)
                begin
                    started_next = 1'b1;
                    if (pos_reg != '1)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (len_reg != '0)
                    begin
                        ring_we            = 1'b1;
                        ptr_next           = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + RING_AW'(1);
                        item_next.op       = OP_TEXT;
                        item_next.remove   = pos_reg >= POS_W'(len_reg);
                        item_next.match_ok = pos_reg >= POS_W'(len_m1);
                        item_next.start    = pos_reg - POS_W'(len_m1);
                    end
                end
            end
            ACT_CLEAR:
            begin
                len_next     = '0;
                pos_next     = '0;
                ptr_next     = '0;
                started_next = 1'b0;
                item_next.op = OP_CLEAR;
            end
            default:
            begin
                item_next.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            pos_reg        <= '0;
            ptr_reg        <= '0;
            started_reg    <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
            if (accept)
            begin
                len_reg     <= len_next;
                pos_reg     <= pos_next;
                ptr_reg     <= ptr_next;
                started_reg <= started_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_letter_reg <= ring_mem[old_addr];
        end
        if (accept && ring_we)
        begin
            ring_mem[ptr_reg] <= letter;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign old_letter = old_letter_reg;

endmodule

### design/sawm_tally.sv
`timescale 1ns / 1ps

module sawm_tally
    import sawm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  item_t               item,
    input  logic [LETTER_W-1:0] old_letter,
    output logic                res_valid,
    output result_t             res
);

    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    // Added letters minus pattern letters, and removed letters, per code.
    logic [CNT_W-1:0] add_mem [0:ALPHABET-1];
    logic [CNT_W-1:0] rem_mem [0:ALPHABET-1];

    logic                s2_valid_reg;
    item_t               s2_item_reg;
    logic [LETTER_W-1:0] s2_old_reg;
    logic [CNT_W-1:0]    add_c_rd_reg, add_o_rd_reg, rem_c_rd_reg, rem_o_rd_reg;
    logic [ALPHABET-1:0] add_vld_reg, add_vld_next;
    logic [ALPHABET-1:0] rem_vld_reg, rem_vld_next;
    logic                add_byp_en_reg, rem_byp_en_reg;
    logic [LETTER_W-1:0] add_byp_addr_reg, rem_byp_addr_reg;
    logic [CNT_W-1:0]    add_byp_data_reg, rem_byp_data_reg;
    logic [TALLY_W-1:0]  diff_reg, diff_next;

    logic [LETTER_W-1:0] c2, o2;
    logic                is_load, mem_op, rem_op, clr_op;
    logic [CNT_W-1:0]    add_c, add_o, rem_c, rem_o;
    logic [CNT_W-1:0]    d_c, d_o, d_o_n, d_c_cur, d_c_n;
    logic                t1_up, t1_dn, t2_up, t2_dn;
    logic                add_we, rem_we;
    logic [CNT_W-1:0]    add_wdata, rem_wdata;

    assign c2      = s2_item_reg.letter;
    assign o2      = s2_old_reg;
    assign is_load = s2_item_reg.op == OP_LOAD;
    assign mem_op  = s2_valid_reg && (is_load || (s2_item_reg.op == OP_TEXT));
    assign rem_op  = s2_valid_reg && (s2_item_reg.op == OP_TEXT) && s2_item_reg.remove;
    assign clr_op  = s2_valid_reg && (s2_item_reg.op == OP_CLEAR);

    always_comb
    begin
        add_c = (add_byp_en_reg && add_byp_addr_reg == c2) ? add_byp_data_reg :
                (add_vld_reg[c2] ? add_c_rd_reg : '0);
        add_o = (add_byp_en_reg && add_byp_addr_reg == o2) ? add_byp_data_reg :
                (add_vld_reg[o2] ? add_o_rd_reg : '0);
        rem_c = (rem_byp_en_reg && rem_byp_addr_reg == c2) ? rem_byp_data_reg :
                (rem_vld_reg[c2] ? rem_c_rd_reg : '0);
        rem_o = (rem_byp_en_reg && rem_byp_addr_reg == o2) ? rem_byp_data_reg :
                (rem_vld_reg[o2] ? rem_o_rd_reg : '0);
    end

    always_comb
    begin
        d_c     = add_c - rem_c;
        d_o     = add_o - rem_o;
        d_o_n   = d_o - ONE;
        t1_up   = rem_op && (d_o == '0);
        t1_dn   = rem_op && (d_o_n == '0);
        d_c_cur = (rem_op && (o2 == c2)) ? d_o_n : d_c;
        d_c_n   = is_load ? d_c_cur - ONE : d_c_cur + ONE;
        t2_up   = mem_op && (d_c_cur == '0);
        t2_dn   = mem_op && (d_c_n == '0);
        diff_next = diff_reg + TALLY_W'(t1_up) + TALLY_W'(t2_up)
                    - TALLY_W'(t1_dn) - TALLY_W'(t2_dn);

        add_we    = mem_op;
        add_wdata = is_load ? add_c - ONE : add_c + ONE;
        rem_we    = rem_op;
        rem_wdata = rem_o + ONE;

        add_vld_next = add_vld_reg;
        rem_vld_next = rem_vld_reg;
        if (clr_op)
        begin
            add_vld_next = '0;
            rem_vld_next = '0;
        end
        else
        begin
            if (add_we)
            begin
                add_vld_next = add_vld_reg | (ALPHABET'(1) << c2);
            end
            if (rem_we)
            begin
                rem_vld_next = rem_vld_reg | (ALPHABET'(1) << o2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            add_vld_reg    <= '0;
            rem_vld_reg    <= '0;
            add_byp_en_reg <= 1'b0;
            rem_byp_en_reg <= 1'b0;
            diff_reg       <= '0;
        end
        else
        begin
            s2_valid_reg   <= item_valid;
            add_vld_reg    <= add_vld_next;
            rem_vld_reg    <= rem_vld_next;
            add_byp_en_reg <= add_we;
            rem_byp_en_reg <= rem_we;
            if (clr_op)
            begin
                diff_reg <= '0;
            end
            else if (mem_op)
            begin
                diff_reg <= diff_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_item_reg      <= item;
        s2_old_reg       <= old_letter;
        add_byp_addr_reg <= c2;
        add_byp_data_reg <= add_wdata;
        rem_byp_addr_reg <= o2;
        rem_byp_data_reg <= rem_wdata;
    end

    always_ff @(posedge clk)
    begin
        add_c_rd_reg <= add_mem[item.letter];
        add_o_rd_reg <= add_mem[old_letter];
        if (add_we)
        begin
            add_mem[c2] <= add_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_c_rd_reg <= rem_mem[item.letter];
        rem_o_rd_reg <= rem_mem[old_letter];
        if (rem_we)
        begin
            rem_mem[o2] <= rem_wdata;
        end
    end

    always_comb
    begin
        res.match       = (s2_item_reg.op == OP_TEXT) && s2_item_reg.match_ok
                          && (diff_next == '0);
        res.start_index = res.match ? s2_item_reg.start : '0;
        res.error       = s2_item_reg.error;
    end

    assign res_valid = s2_valid_reg;

endmodule

### design/sawm_fifo.sv
`timescale 1ns / 1ps

module sawm_fifo
    import sawm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  result_t            push_data,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_data,
    output logic [FIFO_CW-1:0] count
);

    localparam logic [FIFO_AW-1:0] PTR_LAST = FIFO_AW'(FIFO_DEPTH - 1);

    result_t             buf_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg, count_next;
    logic                pop;

    assign pop = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = buf_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

### design/sliding_anagram_window_matcher.sv
`timescale 1ns / 1ps

// Channel  Direction  Signals                     Contents
// s_       in         s_tvalid s_tready s_tdata   letter code; tuser carries the action
//                     s_tuser
// m_       out        m_tvalid m_tready m_tdata   match, start_index, error
//
// One transaction per cycle is sustained while the result queue has room; each result is
// registered in the control stage, the tally stage and the result queue. The rate is set by
// the read-modify-write loop on the two letter-count memories, closed by a one-entry bypass.
// Reset clears all control state and the count valid bits at once; there is no clearing pass.
// s_tready falls when the four-entry result queue plus the transactions in flight reach four.

module sliding_anagram_window_matcher
    import sawm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [4:0] letter, upper bits unused
    input  logic [ACTION_W-1:0]   s_tuser,   // [1:0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] match, [32:1] start_index, [33] error
);

    logic                item_valid;
    item_t               item;
    logic [LETTER_W-1:0] old_letter;
    logic                res_valid;
    result_t             res;
    result_t             out_res;
    logic [FIFO_CW-1:0]  fifo_count;
    logic [FIFO_CW:0]    occupancy;

    assign occupancy = {1'b0, fifo_count} + (FIFO_CW + 1)'(item_valid)
                       + (FIFO_CW + 1)'(res_valid);
    assign s_tready  = occupancy < (FIFO_CW + 1)'(FIFO_DEPTH);

    sawm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (s_tuser),
        .letter     (s_tdata[LETTER_W-1:0]),
        .item_valid (item_valid),
        .item       (item),
        .old_letter (old_letter)
    );

    sawm_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .old_letter (old_letter),
        .res_valid  (res_valid),
        .res        (res)
    );

    sawm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    assign m_tdata = {(OUT_DATA_W - RESULT_W)'(0), out_res};

endmodule

### design/sawm_checker.sv
`timescale 1ns / 1ps

module sawm_checker
    import sawm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result transaction changed or was dropped.");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[RESULT_W-1]))
        else $error("Result carries both a match and an error.");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[POS_W:1] == '0)
        else $error("Start index is nonzero without a match.");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("Result transaction offered right after reset.");

endmodule

bind sliding_anagram_window_matcher sawm_checker u_sawm_checker (.*);

### test/anagram_checker.sv
`timescale 1ns / 1ps

module anagram_checker
    import sawm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [4:0] letter, upper bits unused
    input  logic [ACTION_W-1:0]   s_tuser,   // [1:0] action
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // [0] match, [32:1] start_index, [33] error
    output int                    mismatches,
    output int                    pending,
    output int                    matches_seen,
    output int                    refusals_seen
);

    logic [LEN_W-1:0]    pat_hist [ALPHABET];
    logic [LEN_W-1:0]    win_hist [ALPHABET];
    logic [LETTER_W-1:0] ring [MAX_WINDOW];
    logic [RING_AW-1:0]  ring_wr;
    logic [LEN_W-1:0]    win_len;
    logic [POS_W-1:0]    text_pos;
    logic [TALLY_W-1:0]  tally;
    logic                in_text;

    result_t expected_results [$];
    result_t predicted_result;
    result_t seen_result;
    result_t wanted_result;
    bit      field_bad;

    function automatic void clear_model();
        for (int i = 0; i < ALPHABET; i++)
        begin
            pat_hist[i] = '0;
            win_hist[i] = '0;
        end
        for (int i = 0; i < MAX_WINDOW; i++)
            ring[i] = '0;
        ring_wr  = '0;
        win_len  = '0;
        text_pos = '0;
        tally    = '0;
        in_text  = 1'b0;
    endfunction

    // The tally counts letters whose window and pattern counts differ.
    function automatic void update_tally(logic [LETTER_W-1:0] c, bit was_equal);
        bit now_equal;
        now_equal = (win_hist[c] == pat_hist[c]);
        if (was_equal && !now_equal)
            tally = tally + 1'b1;
        else if (!was_equal && now_equal && tally != 0)
            tally = tally - 1'b1;
    endfunction

    function automatic void shift_window(logic [LETTER_W-1:0] c, bit up);
        bit was_equal;
        was_equal = (win_hist[c] == pat_hist[c]);
        if (up)
            win_hist[c] = win_hist[c] + 1'b1;
        else if (win_hist[c] != 0)
            win_hist[c] = win_hist[c] - 1'b1;
        update_tally(c, was_equal);
    endfunction

    function automatic result_t predict_anagram(logic [ACTION_W-1:0] act,
                                                logic [LETTER_W-1:0] ltr);
        result_t            r;
        logic [POS_W-1:0]   pos;
        logic [RING_AW-1:0] oldest;
        bit                 was_equal;
        r = '0;
        case (act)
            ACT_LOAD:
            begin
                if (in_text || win_len >= MAX_WINDOW || ltr >= ALPHABET)
                    r.error = 1'b1;
                else
                begin
                    was_equal = (win_hist[ltr] == pat_hist[ltr]);
                    pat_hist[ltr] = pat_hist[ltr] + 1'b1;
                    win_len = win_len + 1'b1;
                    update_tally(ltr, was_equal);
                end
            end
            ACT_TEXT:
            begin
                if (ltr < ALPHABET)
                begin
                    pos = text_pos;
                    in_text = 1'b1;
                    if (win_len != 0)
                    begin
                        if (pos >= POS_W'(win_len))
                        begin
                            oldest = ring_wr - win_len[RING_AW-1:0];
                            if (ring[oldest] < ALPHABET)
                                shift_window(ring[oldest], 1'b0);
                        end
                        shift_window(ltr, 1'b1);
                        ring[ring_wr] = ltr;
                        ring_wr = ring_wr + 1'b1;
                        if (pos >= POS_W'(win_len) - 1 && tally == 0)
                        begin
                            r.match       = 1'b1;
                            r.start_index = pos - (POS_W'(win_len) - 1);
                        end
                    end
                    if (text_pos != '1)
                        text_pos = text_pos + 1'b1;
                end
            end
            ACT_CLEAR:
                clear_model();
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            expected_results.delete();
            mismatches    <= 0;
            pending       <= 0;
            matches_seen  <= 0;
            refusals_seen <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_result = predict_anagram(s_tuser, s_tdata[LETTER_W-1:0]);
                expected_results = {expected_results, predicted_result};
            end
            if (m_tvalid && m_tready)
            begin
                seen_result = m_tdata[RESULT_W-1:0];
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: %s%0d %s%0d %s%0d",
                           "match=", seen_result.match,
                           "start_index=", seen_result.start_index,
                           "error=", seen_result.error);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    wanted_result = expected_results.pop_front();
                    field_bad = 1'b0;
                    if (seen_result.match !== wanted_result.match)
                    begin
                        $error("match: expected %0d, actual %0d",
                               wanted_result.match, seen_result.match);
                        field_bad = 1'b1;
                    end
                    if (seen_result.start_index !== wanted_result.start_index)
                    begin
                        $error("start_index: expected %0d, actual %0d",
                               wanted_result.start_index, seen_result.start_index);
                        field_bad = 1'b1;
                    end
                    if (seen_result.error !== wanted_result.error)
                    begin
                        $error("error: expected %0d, actual %0d",
                               wanted_result.error, seen_result.error);
                        field_bad = 1'b1;
                    end
                    if (field_bad)
                        mismatches <= mismatches + 1;
                    if (wanted_result.match)
                        matches_seen <= matches_seen + 1;
                    if (wanted_result.error)
                        refusals_seen <= refusals_seen + 1;
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sawm_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 1800;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int matches_seen;
    int refusals_seen;

    logic                quiet = 1'b0;
    int                  sent = 0;
    int                  idle_cycles = 0;
    int unsigned         stall_left = 0;
    logic [LETTER_W-1:0] pattern_letters [$];
    logic [LETTER_W-1:0] anagram_letters [$];
    logic [LETTER_W-1:0] pick;
    logic [LETTER_W-1:0] swap_letter;
    int unsigned         base_letter;
    int unsigned         span;
    int unsigned         pat_len;
    int unsigned         text_len;
    int unsigned         text_done;
    int unsigned         roll;
    int unsigned         swap_at;

    sliding_anagram_window_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    anagram_checker anagram_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .matches_seen  (matches_seen),
        .refusals_seen (refusals_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (quiet)
            m_tready <= 1'b1;
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left = ($urandom_range(0, 99) < 30) ? idle_len() : 0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send(input logic [ACTION_W-1:0] act, input logic [LETTER_W-1:0] ltr);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= IN_DATA_W'(ltr);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic make_anagram();
        anagram_letters = pattern_letters;
        for (int i = anagram_letters.size() - 1; i > 0; i--)
        begin
            swap_at = $urandom_range(0, i);
            swap_letter = anagram_letters[i];
            anagram_letters[i] = anagram_letters[swap_at];
            anagram_letters[swap_at] = swap_letter;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-pattern text, a load after text, bad codes, then a short matching run.
        send(ACT_TEXT, 5'd0);
        send(ACT_LOAD, 5'd3);
        send(ACT_CLEAR, 5'd0);
        send(ACT_LOAD, 5'd25);
        send(ACT_LOAD, 5'd0);
        send(ACT_LOAD, 5'd26);
        send(ACT_LOAD, 5'd31);
        send(ACT_TEXT, 5'd31);
        send(ACT_TEXT, 5'd0);
        send(ACT_TEXT, 5'd25);
        send(ACT_TEXT, 5'd0);
        send(ACT_TEXT, 5'd3);
        send(ACT_UNUSED, 5'd17);
        send(ACT_CLEAR, 5'd9);
        send(ACT_LOAD, 5'd0);
        send(ACT_LOAD, 5'd1);
        send(ACT_LOAD, 5'd0);
        send(ACT_TEXT, 5'd1);
        send(ACT_TEXT, 5'd0);
        send(ACT_TEXT, 5'd0);
        send(ACT_TEXT, 5'd1);
        send(ACT_TEXT, 5'd2);
        wait_all_results();

        // A full-size pattern, refused extra letters, and the first text letters after it.
        quiet <= 1'b1;
        send(ACT_CLEAR, 5'($urandom_range(0, 31)));
        pattern_letters.delete();
        repeat (MAX_WINDOW)
        begin
            pick = LETTER_W'($urandom_range(0, ALPHABET - 1));
            send(ACT_LOAD, pick);
        end
        send(ACT_LOAD, 5'd4);
        send(ACT_LOAD, 5'd30);
        quiet <= 1'b0;
        repeat (8)
            send(ACT_TEXT, 5'($urandom_range(0, ALPHABET - 1)));
        send(ACT_LOAD, 5'd7);
        wait_all_results();

        base_letter = 0;
        span = ALPHABET;
        while (sent < ITEM_TARGET)
        begin
            quiet <= ($urandom_range(0, 9) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                send(ACT_CLEAR, 5'($urandom_range(0, 31)));
                span = $urandom_range(2, ALPHABET);
                base_letter = $urandom_range(0, ALPHABET - span);
                pat_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(0, 8);
                pattern_letters.delete();
                repeat (pat_len)
                begin
                    pick = LETTER_W'(base_letter + $urandom_range(0, span - 1));
                    pattern_letters = {pattern_letters, pick};
                    send(ACT_LOAD, pick);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 2))
                    send(ACT_LOAD, 5'($urandom_range(0, 31)));
            end
            text_len = $urandom_range(4, 60);
            text_done = 0;
            while (text_done < text_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 30 && pattern_letters.size() != 0)
                begin
                    make_anagram();
                    foreach (anagram_letters[i])
                        send(ACT_TEXT, anagram_letters[i]);
                    text_done += anagram_letters.size();
                end
                else if (roll < 36)
                begin
                    case ($urandom_range(0, 3))
                        0: send(ACT_TEXT, 5'($urandom_range(ALPHABET, 31)));
                        1: send(ACT_UNUSED, 5'($urandom_range(0, 31)));
                        2: send(ACT_LOAD, 5'($urandom_range(0, 31)));
                        default: send(ACT_TEXT, 5'($urandom_range(0, ALPHABET - 1)));
                    endcase
                    text_done++;
                end
                else
                begin
                    send(ACT_TEXT, 5'(base_letter + $urandom_range(0, span - 1)));
                    text_done++;
                end
            end
            if ($urandom_range(0, 7) == 0)
                wait_all_results();
        end

        quiet <= 1'b0;
        wait_all_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d input transactions; %0d windows matched, %0d pattern letters refused.",
                 sent, matches_seen, refusals_seen);
        $display("Covered corner cases, a full-size pattern with refusals, and random segments.");
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
design/sawm_pkg.sv
design/sawm_ctrl.sv
design/sawm_tally.sv
design/sawm_fifo.sv
design/sliding_anagram_window_matcher.sv
design/sawm_checker.sv
test/anagram_checker.sv
test/testbench.sv
